// ===== hw/rtl/qnco_pkg.sv =====
package qnco_pkg;

	// Fixed field widths
	localparam int unsigned INC_W  = 32;
	localparam int unsigned FLD_W  = 16;
	localparam int unsigned PH32_W = 32;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Q30 constants
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF    = 31'h2000_0000;

	// Horner steps of the cosine series; the sine series uses steps 1 to NSTEP-1
	localparam int unsigned NSTEP = 6;

	// Divide by a small constant: q = (n * RCP) >> SH, exact for any 32-bit n
	localparam logic [32:0] COS_RCP [NSTEP] = '{
		33'((65'd1 << 40) / 65'd132 + 65'd1),
		33'((65'd1 << 39) / 65'd90 + 65'd1),
		33'((65'd1 << 38) / 65'd56 + 65'd1),
		33'((65'd1 << 37) / 65'd30 + 65'd1),
		33'((65'd1 << 36) / 65'd12 + 65'd1),
		33'((65'd1 << 33) / 65'd2 + 65'd1)
	};
	localparam int unsigned COS_SH [NSTEP] = '{40, 39, 38, 37, 36, 33};

	// Entry 0 is never used: the sine series has one term less
	localparam logic [32:0] SIN_RCP [NSTEP] = '{
		33'd0,
		33'((65'd1 << 39) / 65'd110 + 65'd1),
		33'((65'd1 << 39) / 65'd72 + 65'd1),
		33'((65'd1 << 38) / 65'd42 + 65'd1),
		33'((65'd1 << 37) / 65'd20 + 65'd1),
		33'((65'd1 << 35) / 65'd6 + 65'd1)
	};
	localparam int unsigned SIN_SH [NSTEP] = '{32, 39, 39, 38, 37, 35};

	typedef logic signed [FLD_W-1:0] fld_t;

	// One queued sample with the phase it was tagged with
	typedef struct packed {
		logic              accumulate;
		fld_t              in_re;
		fld_t              in_im;
		logic [PH32_W-1:0] ph;
	} qnco_item_t;

endpackage

// ===== hw/rtl/qnco_ifs.sv =====
interface qnco_in_if;
	import qnco_pkg::*;

	logic valid;
	logic ready;
	logic accumulate;
	fld_t in_re;
	fld_t in_im;

	modport source(output valid, output accumulate, output in_re, output in_im, input ready);
	modport sink(input valid, input accumulate, input in_re, input in_im, output ready);
endinterface

interface qnco_out_if;
	import qnco_pkg::*;

	logic valid;
	logic ready;
	fld_t out_re;
	fld_t out_im;

	modport source(output valid, output out_re, output out_im, input ready);
	modport sink(input valid, input out_re, input out_im, output ready);
endinterface

// ===== hw/rtl/qnco_front.sv =====
module qnco_front #(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	qnco_in_if.sink                       sample,
	input  logic                          cfg_wr_en,
	input  logic [qnco_pkg::INC_W-1:0]    cfg_wr_data,
	input  logic                          full,
	output logic                          push,
	output qnco_pkg::qnco_item_t          item
);
	import qnco_pkg::*;

	logic [PHASE_BITS-1:0] phase_q;
	logic [INC_W-1:0]      inc_q;
	logic [PHASE_BITS-1:0] inc_ext;

	// Take a transfer whenever the queue has room
	assign sample.ready = ~full;
	assign push         = sample.valid & ~full;

	// Align the accumulator to a 32-bit turn fraction and tag the sample
	assign item.accumulate = sample.accumulate;
	assign item.in_re      = sample.in_re;
	assign item.in_im      = sample.in_im;
	assign item.ph         = PH32_W'({phase_q, {PH32_W{1'b0}}} >> PHASE_BITS);

	// Sign-extend or wrap the step to the accumulator width
	assign inc_ext = PHASE_BITS'(signed'(inc_q));

	// Hold the step register, advance the phase on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				inc_q <= cfg_wr_data;
			end
			if (push) begin
				phase_q <= phase_q + inc_ext;
			end
		end
	end

endmodule

// ===== hw/rtl/qnco_queue.sv =====
module qnco_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qnco_pkg::qnco_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_vld,
	output qnco_pkg::qnco_item_t head
);
	import qnco_pkg::*;

	qnco_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/qnco_back.sv =====
module qnco_back #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_vld,
	input  qnco_pkg::qnco_item_t head,
	output logic                 pop,
	qnco_out_if.source           result
);
	import qnco_pkg::*;

	localparam int unsigned AW   = SAMPLE_BITS - 1;
	localparam int unsigned SW   = ((SAMPLE_BITS > FLD_W) ? SAMPLE_BITS : FLD_W) + 1;
	localparam int unsigned NSTG = 2 * NSTEP + 5;
	localparam int unsigned LAST = NSTG - 1;
	localparam int unsigned PW   = AW + 31;

	localparam logic [AW-1:0]        AMP  = {AW{1'b1}};
	localparam logic signed [SW-1:0] SMAX = {{(SW - AW){1'b0}}, {AW{1'b1}}};
	localparam logic signed [SW-1:0] SMIN = ~SMAX;

	localparam logic [1:0] QD_FIRST  = 2'd0;
	localparam logic [1:0] QD_SECOND = 2'd1;
	localparam logic [1:0] QD_THIRD  = 2'd2;

	typedef struct packed {
		logic [1:0]  quad;
		logic        accumulate;
		fld_t        in_re;
		fld_t        in_im;
		logic [30:0] x;
		logic [31:0] x2;
	} carry_t;

	logic [NSTG-1:0] vld_s;
	carry_t          car_s [NSTG];
	logic            adv;

	// Horner step registers: products after the first stage, new terms after the second
	logic [31:0]        cn_s [NSTEP];
	logic signed [31:0] ct_s [NSTEP];
	logic [31:0]        sn_s [1:NSTEP-1];
	logic signed [31:0] st_s [1:NSTEP-1];

	logic [30:0]    sp_s15;
	logic signed [31:0] cf_s15;
	logic [AW-1:0]  cs_s16;
	logic [AW-1:0]  ss_s16;
	fld_t           out_re_s17;
	fld_t           out_im_s17;

	logic [60:0] x_prod;
	logic [30:0] x_d;
	logic [61:0] x2_prod;
	logic [31:0] x2_d;

	// Move every stage together unless the output is held
	assign adv = ~vld_s[LAST] | result.ready;
	assign pop = adv & head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], head_vld};
		end
	end

	// Angle within the quadrant, and its square
	assign x_prod  = 61'(head.ph[29:0]) * 61'(HALF_PI_Q30);
	assign x_d     = 31'(x_prod >> 30);
	assign x2_prod = 62'(car_s[0].x) * 62'(car_s[0].x);
	assign x2_d    = 32'(x2_prod >> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s[0].quad       <= head.ph[31:30];
			car_s[0].accumulate <= head.accumulate;
			car_s[0].in_re      <= head.in_re;
			car_s[0].in_im      <= head.in_im;
			car_s[0].x          <= x_d;
			car_s[0].x2         <= '0;
			car_s[1]            <= '{quad: car_s[0].quad, accumulate: car_s[0].accumulate,
				in_re: car_s[0].in_re, in_im: car_s[0].in_im, x: car_s[0].x, x2: x2_d};
			for (int i = 2; i < NSTG; i++) begin
				car_s[i] <= car_s[i-1];
			end
		end
	end

	// Series evaluation, innermost term first, two stages per term
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [30:0]        ct_in;
		logic [62:0]        cp;
		logic [64:0]        cq_p;
		logic [31:0]        cq;
		logic signed [33:0] ct_d;

		if (k == 0) begin : g_cfirst
			assign ct_in = Q30_ONE;
		end else begin : g_cnext
			assign ct_in = ct_s[k-1][30:0];
		end

		assign cp   = 63'(car_s[1+2*k].x2) * 63'(ct_in);
		assign cq_p = 65'(cn_s[k]) * 65'(COS_RCP[k]);
		assign cq   = 32'(cq_p >> COS_SH[k]);
		assign ct_d = $signed({3'b000, Q30_ONE}) - $signed({2'b00, cq});

		always_ff @(posedge clk) begin
			if (adv) begin
				cn_s[k] <= 32'(cp >> 30);
				ct_s[k] <= 32'(ct_d);
			end
		end

		if (k > 0) begin : g_sin
			logic [30:0]        st_in;
			logic [62:0]        sp;
			logic [64:0]        sq_p;
			logic [31:0]        sq;
			logic signed [33:0] st_d;

			if (k == 1) begin : g_sfirst
				assign st_in = Q30_ONE;
			end else begin : g_snext
				assign st_in = st_s[k-1][30:0];
			end

			assign sp   = 63'(car_s[1+2*k].x2) * 63'(st_in);
			assign sq_p = 65'(sn_s[k]) * 65'(SIN_RCP[k]);
			assign sq   = 32'(sq_p >> SIN_SH[k]);
			assign st_d = $signed({3'b000, Q30_ONE}) - $signed({2'b00, sq});

			always_ff @(posedge clk) begin
				if (adv) begin
					sn_s[k] <= 32'(sp >> 30);
					st_s[k] <= 32'(st_d);
				end
			end
		end
	end

	// Sine times the angle; hold the cosine alongside
	logic [61:0] sx_prod;
	assign sx_prod = 62'(car_s[LAST-3].x) * 62'(st_s[NSTEP-1][30:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s15 <= 31'(sx_prod >> 30);
			cf_s15 <= ct_s[NSTEP-1];
		end
	end

	// Clamp to [0, 1] and scale to the sample amplitude with rounding
	logic [30:0]   c_cl;
	logic [30:0]   s_cl;
	logic [PW-1:0] c_sc;
	logic [PW-1:0] s_sc;

	always_comb begin
		if (cf_s15[31]) begin
			c_cl = '0;
		end else if (cf_s15 > $signed({1'b0, Q30_ONE})) begin
			c_cl = Q30_ONE;
		end else begin
			c_cl = cf_s15[30:0];
		end
		s_cl = (sp_s15 > Q30_ONE) ? Q30_ONE : sp_s15;
	end

	assign c_sc = PW'(c_cl) * PW'(AMP) + PW'(Q30_HALF);
	assign s_sc = PW'(s_cl) * PW'(AMP) + PW'(Q30_HALF);

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s16 <= c_sc[AW+29:30];
			ss_s16 <= s_sc[AW+29:30];
		end
	end

	// Rotate into the quadrant, add the incoming sample when accumulate is set, saturate
	logic signed [SW-1:0] pc;
	logic signed [SW-1:0] ps;
	logic signed [SW-1:0] re_t;
	logic signed [SW-1:0] im_t;
	logic signed [SW-1:0] re_sum;
	logic signed [SW-1:0] im_sum;
	logic signed [SW-1:0] re_sat;
	logic signed [SW-1:0] im_sat;

	assign pc = signed'(SW'(cs_s16));
	assign ps = signed'(SW'(ss_s16));

	always_comb begin
		case (car_s[LAST-1].quad)
			QD_FIRST: begin
				re_t = pc;
				im_t = ps;
			end
			QD_SECOND: begin
				re_t = -ps;
				im_t = pc;
			end
			QD_THIRD: begin
				re_t = -pc;
				im_t = -ps;
			end
			default: begin
				re_t = ps;
				im_t = -pc;
			end
		endcase

		if (car_s[LAST-1].accumulate) begin
			re_sum = re_t + SW'(car_s[LAST-1].in_re);
			im_sum = im_t + SW'(car_s[LAST-1].in_im);
		end else begin
			re_sum = re_t;
			im_sum = im_t;
		end

		if (re_sum > SMAX) begin
			re_sat = SMAX;
		end else if (re_sum < SMIN) begin
			re_sat = SMIN;
		end else begin
			re_sat = re_sum;
		end

		if (im_sum > SMAX) begin
			im_sat = SMAX;
		end else if (im_sum < SMIN) begin
			im_sat = SMIN;
		end else begin
			im_sat = im_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_re_s17 <= re_sat[FLD_W-1:0];
			out_im_s17 <= im_sat[FLD_W-1:0];
		end
	end

	assign result.valid  = vld_s[LAST];
	assign result.out_re = out_re_s17;
	assign result.out_im = out_im_s17;

endmodule

// ===== hw/rtl/quadrature_nco_unit.sv =====
// Quadrature oscillator with optional mix into an incoming complex stream.
// Channels: sample (valid/ready, fields accumulate, in_re, in_im) in, and
// result (valid/ready, fields out_re, out_im) out. Each sample transfer
// yields one result: cosine and sine of the current phase scaled to full
// scale, either replacing the sample or added to it with saturation. The
// phase then advances by the signed step held in inc_q. The user must write
// it through cfg_wr_en / cfg_wr_data only while no sample is in flight; the
// block itself does not enforce this. Throughput: one sample per cycle while
// the receiver keeps ready high. Results come from the series evaluation
// pipeline (two multiply stages per series term, eleven terms split over two
// parallel chains), which is fed from the input queue.
// Reset clears the phase and the step to zero and empties the queue and the
// pipeline. When the receiver holds ready low while a result is waiting, the
// whole pipeline holds; the four-entry queue keeps taking samples until it
// fills, then sample.ready drops. No result is dropped or repeated.
module quadrature_nco_unit #(
	parameter int unsigned PHASE_BITS  = 32,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	qnco_in_if.sink                    sample,
	qnco_out_if.source                 result,
	input  logic                       cfg_wr_en,
	input  logic [qnco_pkg::INC_W-1:0] cfg_wr_data
);
	import qnco_pkg::*;

	logic       push;
	logic       full;
	logic       pop;
	logic       head_vld;
	qnco_item_t push_item;
	qnco_item_t head;

	qnco_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.full       (full),
		.push       (push),
		.item       (push_item)
	);

	qnco_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head)
	);

	qnco_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_vld(head_vld),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

endmodule
